[rtl/mrlp_pkg.sv]
// shared types and constants of the modem reply line parser
package mrlp_pkg;

	localparam int VALUE_W = 19;

	typedef enum logic [1:0] {
		OP_BYTE  = 2'd0,
		OP_TICK  = 2'd1,
		OP_START = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		JOB_TIMEOUT = 2'd0,
		JOB_MISSING = 2'd1,
		JOB_PARSE   = 2'd2
	} job_kind_t;

	typedef enum logic [1:0] {
		BK_IDLE = 2'd0,
		BK_READ = 2'd1,
		BK_DONE = 2'd2
	} back_state_t;

	localparam logic [1:0] STATUS_PARSED  = 2'd0;
	localparam logic [1:0] STATUS_MISSING = 2'd1;
	localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

	localparam logic [7:0] CHAR_CR = 8'h0d;
	localparam logic [7:0] CHAR_LF = 8'h0a;
	localparam logic [7:0] CHAR_U  = 8'h55;
	localparam logic [7:0] CHAR_C  = 8'h43;
	localparam logic [7:0] CHAR_ZERO = 8'h30;

	localparam logic [31:0] KEY_TEMP = 32'h74656d70;
	localparam logic [31:0] KEY_WIND = 32'h77696e64;

	localparam logic signed [VALUE_W-1:0] FAIL_VALUE = 19'sd15;

	localparam logic [7:0] START_TIMEOUT_RST = 8'd25;
	localparam logic [7:0] LINE_TIMEOUT_RST  = 8'd15;

	localparam logic [1:0] REG_START_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_LINE_TIMEOUT  = 2'd1;

	// digit offset after the key for each of the four digits
	function automatic logic [3:0] digit_offset(input logic [1:0] idx);
		logic [3:0] off;
		case (idx)
			2'd0: off = 4'd5;
			2'd1: off = 4'd6;
			2'd2: off = 4'd8;
			default: off = 4'd9;
		endcase
		return off;
	endfunction

	function automatic logic signed [VALUE_W-1:0] digit_weight(input logic [1:0] idx);
		logic signed [VALUE_W-1:0] w;
		case (idx)
			2'd0: w = 19'sd1000;
			2'd1: w = 19'sd100;
			2'd2: w = 19'sd10;
			default: w = 19'sd1;
		endcase
		return w;
	endfunction

endpackage

[rtl/modem_reply_line_parser_core.sv]
// Modem reply line parser. Bytes, timeout ticks and read starts enter on the
// slave stream; the front part counts the timeout, assembles lines of up to
// LINE_BYTES bytes and tracks the first "temp" and "wind" keys, taking one word
// per cycle while the queue has room and no stored line awaits reading. A line
// beginning UC, or a full buffer, ends the read; with both keys it is decoded by
// the back part, which reads the eight digit bytes from the line store one per
// cycle while the input is held. Results leave through a register on the master
// stream, and a two-entry job queue lets the front keep taking words while a
// result waits. Registers: start_timeout at 0x0, line_timeout at 0x4.
module modem_reply_line_parser_core #(
	parameter int LINE_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // rx_byte
	input  logic [1:0]  s_axis_tuser,  // operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // temperature [18:0], wind_speed [37:19], zeros
	output logic [1:0]  m_axis_tuser,  // status
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = $clog2(LINE_BYTES);
	localparam int LEN_W = $clog2(LINE_BYTES + 1);
	localparam int JOB_W = 2 + LEN_W + 2 * AW;
	localparam int VW = mrlp_pkg::VALUE_W;

	logic [7:0] start_timeout_q;
	logic [7:0] line_timeout_q;
	logic       cfg_write;
	logic [1:0] reg_index;

	logic                q_full, q_not_empty, q_pop;
	logic [JOB_W-1:0]    q_push_data, q_head;
	logic                job_push;
	mrlp_pkg::job_kind_t job_kind, head_kind;
	logic [LEN_W-1:0]    job_len;
	logic [AW-1:0]       job_temp_pos, job_wind_pos;
	logic                mem_we;
	logic [AW-1:0]       mem_addr;
	logic [7:0]          mem_data;
	logic                parse_done;
	logic [VW-1:0]       out_temp, out_wind;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign reg_index = {1'b0, paddr[2]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_timeout_q <= mrlp_pkg::START_TIMEOUT_RST;
			line_timeout_q  <= mrlp_pkg::LINE_TIMEOUT_RST;
		end else if (cfg_write) begin
			if (reg_index == mrlp_pkg::REG_START_TIMEOUT) begin
				start_timeout_q <= pwdata[7:0];
			end else begin
				line_timeout_q <= pwdata[7:0];
			end
		end
	end

	assign prdata = (reg_index == mrlp_pkg::REG_START_TIMEOUT) ? {24'd0, start_timeout_q}
		: {24'd0, line_timeout_q};

	mrlp_front #(
		.LINE_BYTES(LINE_BYTES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.op           (s_axis_tuser),
		.rx_byte      (s_axis_tdata),
		.start_timeout(start_timeout_q),
		.line_timeout (line_timeout_q),
		.q_full       (q_full),
		.parse_done   (parse_done),
		.job_push     (job_push),
		.job_kind     (job_kind),
		.job_len      (job_len),
		.job_temp_pos (job_temp_pos),
		.job_wind_pos (job_wind_pos),
		.mem_we       (mem_we),
		.mem_addr     (mem_addr),
		.mem_data     (mem_data)
	);

	assign q_push_data = {job_kind, job_len, job_temp_pos, job_wind_pos};

	mrlp_job_queue #(
		.W(JOB_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_data(q_push_data),
		.pop      (q_pop),
		.full     (q_full),
		.not_empty(q_not_empty),
		.head     (q_head)
	);

	assign head_kind = mrlp_pkg::job_kind_t'(q_head[JOB_W-1 -: 2]);

	mrlp_back #(
		.LINE_BYTES(LINE_BYTES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.mem_we      (mem_we),
		.mem_addr    (mem_addr),
		.mem_data    (mem_data),
		.job_valid   (q_not_empty),
		.job_kind    (head_kind),
		.job_len     (q_head[2*AW +: LEN_W]),
		.job_temp_pos(q_head[AW +: AW]),
		.job_wind_pos(q_head[AW-1:0]),
		.job_pop     (q_pop),
		.parse_done  (parse_done),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_status  (m_axis_tuser),
		.out_temp    (out_temp),
		.out_wind    (out_wind)
	);

	assign m_axis_tdata = {2'b00, out_wind, out_temp};

endmodule

[rtl/mrlp_job_queue.sv]
// two-entry queue of jobs between the front and back parts
module mrlp_job_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic         full,
	output logic         not_empty,
	output logic [W-1:0] head
);

	logic [W-1:0] entry_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

[rtl/mrlp_front.sv]
// front part: timeout counting, line assembly, key search and job issue
module mrlp_front #(
	parameter int LINE_BYTES = 64,
	parameter int AW = $clog2(LINE_BYTES),
	parameter int LEN_W = $clog2(LINE_BYTES + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          op,
	input  logic [7:0]          rx_byte,
	input  logic [7:0]          start_timeout,
	input  logic [7:0]          line_timeout,
	input  logic                q_full,
	input  logic                parse_done,
	output logic                job_push,
	output mrlp_pkg::job_kind_t job_kind,
	output logic [LEN_W-1:0]    job_len,
	output logic [AW-1:0]       job_temp_pos,
	output logic [AW-1:0]       job_wind_pos,
	output logic                mem_we,
	output logic [AW-1:0]       mem_addr,
	output logic [7:0]          mem_data
);

	localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(LINE_BYTES);

	logic [LEN_W-1:0] len_q, len_d;
	logic [7:0]       ticks_q, ticks_d;
	logic [23:0]      last3_q, last3_d;
	logic [AW-1:0]    temp_pos_q, temp_pos_d;
	logic             temp_found_q, temp_found_d;
	logic [AW-1:0]    wind_pos_q, wind_pos_d;
	logic             wind_found_q, wind_found_d;
	logic [7:0]       first0_q, first0_d;
	logic [7:0]       first1_q, first1_d;
	logic             parse_wait_q;
	logic             accept;
	logic [31:0]      window;
	logic [7:0]       ticks_dec;
	logic [LEN_W-1:0] len_inc;
	logic             is_uc;

	assign in_ready = !q_full && !parse_wait_q;
	assign accept   = in_valid && in_ready;
	assign window   = {last3_q, rx_byte};
	assign ticks_dec = ticks_q - 8'd1;
	assign len_inc  = len_q + LEN_W'(1);
	assign is_uc    = (len_q >= LEN_W'(2)) && (first0_q == mrlp_pkg::CHAR_U)
		&& (first1_q == mrlp_pkg::CHAR_C);
	assign mem_addr = len_q[AW-1:0];
	assign mem_data = rx_byte;

	always_comb begin
		len_d        = len_q;
		ticks_d      = ticks_q;
		last3_d      = last3_q;
		temp_pos_d   = temp_pos_q;
		temp_found_d = temp_found_q;
		wind_pos_d   = wind_pos_q;
		wind_found_d = wind_found_q;
		first0_d     = first0_q;
		first1_d     = first1_q;
		job_push     = 1'b0;
		job_kind     = mrlp_pkg::JOB_TIMEOUT;
		job_len      = len_q;
		job_temp_pos = temp_pos_q;
		job_wind_pos = wind_pos_q;
		mem_we       = 1'b0;
		if (accept) begin
			if (op == mrlp_pkg::OP_START) begin
				ticks_d  = start_timeout;
				job_push = (start_timeout == 8'd0);
			end else if (ticks_q != 8'd0 && op != mrlp_pkg::OP_NONE) begin
				if (op == mrlp_pkg::OP_TICK) begin
					ticks_d  = ticks_dec;
					job_push = (ticks_dec == 8'd0);
				end else if (rx_byte == mrlp_pkg::CHAR_CR) begin
					len_d        = '0;
					last3_d      = '0;
					temp_pos_d   = '0;
					temp_found_d = 1'b0;
					wind_pos_d   = '0;
					wind_found_d = 1'b0;
					if (is_uc) begin
						ticks_d  = 8'd0;
						job_push = 1'b1;
						job_kind = (temp_found_q && wind_found_q) ? mrlp_pkg::JOB_PARSE
							: mrlp_pkg::JOB_MISSING;
					end else begin
						ticks_d  = line_timeout;
						job_push = (line_timeout == 8'd0);
					end
				end else if (len_q == '0 && rx_byte == mrlp_pkg::CHAR_LF) begin
					// line feed at line start is skipped
				end else if (len_q >= FULL_LEN) begin
					len_d        = '0;
					last3_d      = '0;
					temp_pos_d   = '0;
					temp_found_d = 1'b0;
					wind_pos_d   = '0;
					wind_found_d = 1'b0;
				end else begin
					mem_we = 1'b1;
					if (len_q == '0) begin
						first0_d = rx_byte;
					end
					if (len_q == LEN_W'(1)) begin
						first1_d = rx_byte;
					end
					if (len_q >= LEN_W'(3)) begin
						if (window == mrlp_pkg::KEY_TEMP && !temp_found_q) begin
							temp_found_d = 1'b1;
							temp_pos_d   = len_q[AW-1:0] - AW'(3);
						end
						if (window == mrlp_pkg::KEY_WIND && !wind_found_q) begin
							wind_found_d = 1'b1;
							wind_pos_d   = len_q[AW-1:0] - AW'(3);
						end
					end
					last3_d = window[23:0];
					len_d   = len_inc;
					if (len_inc >= FULL_LEN) begin
						// full buffer ends the read like a reply line
						job_push     = 1'b1;
						job_kind     = (temp_found_d && wind_found_d) ? mrlp_pkg::JOB_PARSE
							: mrlp_pkg::JOB_MISSING;
						job_len      = len_inc;
						job_temp_pos = temp_pos_d;
						job_wind_pos = wind_pos_d;
						ticks_d      = 8'd0;
						len_d        = '0;
						last3_d      = '0;
						temp_pos_d   = '0;
						temp_found_d = 1'b0;
						wind_pos_d   = '0;
						wind_found_d = 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q        <= '0;
			ticks_q      <= 8'd0;
			last3_q      <= 24'd0;
			temp_pos_q   <= '0;
			temp_found_q <= 1'b0;
			wind_pos_q   <= '0;
			wind_found_q <= 1'b0;
			first0_q     <= 8'd0;
			first1_q     <= 8'd0;
			parse_wait_q <= 1'b0;
		end else begin
			len_q        <= len_d;
			ticks_q      <= ticks_d;
			last3_q      <= last3_d;
			temp_pos_q   <= temp_pos_d;
			temp_found_q <= temp_found_d;
			wind_pos_q   <= wind_pos_d;
			wind_found_q <= wind_found_d;
			first0_q     <= first0_d;
			first1_q     <= first1_d;
			// hold off new bytes until the stored line has been read
			if (job_push && job_kind == mrlp_pkg::JOB_PARSE) begin
				parse_wait_q <= 1'b1;
			end else if (parse_done) begin
				parse_wait_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/mrlp_back.sv]
// back part: line store, digit decoding and the result register
module mrlp_back #(
	parameter int LINE_BYTES = 64,
	parameter int AW = $clog2(LINE_BYTES),
	parameter int LEN_W = $clog2(LINE_BYTES + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                mem_we,
	input  logic [AW-1:0]       mem_addr,
	input  logic [7:0]          mem_data,
	input  logic                job_valid,
	input  mrlp_pkg::job_kind_t job_kind,
	input  logic [LEN_W-1:0]    job_len,
	input  logic [AW-1:0]       job_temp_pos,
	input  logic [AW-1:0]       job_wind_pos,
	output logic                job_pop,
	output logic                parse_done,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          out_status,
	output logic [mrlp_pkg::VALUE_W-1:0] out_temp,
	output logic [mrlp_pkg::VALUE_W-1:0] out_wind
);

	localparam int POS_W = LEN_W + 1;
	localparam int VW = mrlp_pkg::VALUE_W;

	logic [7:0] line_mem [LINE_BYTES];

	mrlp_pkg::back_state_t state_q, state_d;
	logic [2:0]           step_q, step_d;
	logic                 rd_valid_s1;
	logic [2:0]           rd_step_s1;
	logic                 rd_inrange_s1;
	logic [7:0]           rd_data_s1;
	logic signed [VW-1:0] temp_acc_q, wind_acc_q;
	logic                 out_valid_q;
	logic [1:0]           out_status_q;
	logic [VW-1:0]        out_temp_q, out_wind_q;
	logic                 out_free;
	logic                 rd_en;
	logic                 load_fail;
	logic                 load_parse;
	logic                 start_parse;
	logic [AW-1:0]        key_pos;
	logic [POS_W-1:0]     rd_pos;
	logic signed [VW-1:0] char_val;
	logic signed [VW-1:0] product;

	assign out_free = !out_valid_q || out_ready;
	assign key_pos  = step_q[2] ? job_wind_pos : job_temp_pos;
	assign rd_pos   = POS_W'(key_pos) + POS_W'(mrlp_pkg::digit_offset(step_q[1:0]));

	always_comb begin
		state_d     = state_q;
		step_d      = step_q;
		rd_en       = 1'b0;
		load_fail   = 1'b0;
		load_parse  = 1'b0;
		start_parse = 1'b0;
		case (state_q)
			mrlp_pkg::BK_IDLE: begin
				if (job_valid) begin
					if (job_kind == mrlp_pkg::JOB_PARSE) begin
						start_parse = 1'b1;
						step_d      = 3'd0;
						state_d     = mrlp_pkg::BK_READ;
					end else if (out_free) begin
						load_fail = 1'b1;
					end
				end
			end
			mrlp_pkg::BK_READ: begin
				rd_en  = 1'b1;
				step_d = step_q + 3'd1;
				if (step_q == 3'd7) begin
					state_d = mrlp_pkg::BK_DONE;
				end
			end
			mrlp_pkg::BK_DONE: begin
				if (!rd_valid_s1 && out_free) begin
					load_parse = 1'b1;
					state_d    = mrlp_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = mrlp_pkg::BK_IDLE;
			end
		endcase
	end

	assign job_pop    = load_fail || load_parse;
	assign parse_done = load_parse;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			line_mem[mem_addr] <= mem_data;
		end
		if (rd_en) begin
			rd_data_s1 <= line_mem[rd_pos[AW-1:0]];
		end
		rd_step_s1    <= step_q;
		rd_inrange_s1 <= (rd_pos < POS_W'(job_len));
	end

	// bytes past the line read as zero; a stored byte is a signed character
	assign char_val = (rd_inrange_s1 ? VW'(signed'(rd_data_s1)) : '0)
		- VW'(mrlp_pkg::CHAR_ZERO);
	assign product  = VW'(char_val * mrlp_pkg::digit_weight(rd_step_s1[1:0]));

	always_ff @(posedge clk) begin
		if (start_parse) begin
			temp_acc_q <= '0;
			wind_acc_q <= '0;
		end else if (rd_valid_s1) begin
			if (rd_step_s1[2]) begin
				wind_acc_q <= wind_acc_q + product;
			end else begin
				temp_acc_q <= temp_acc_q + product;
			end
		end
		if (load_fail) begin
			out_status_q <= (job_kind == mrlp_pkg::JOB_MISSING) ? mrlp_pkg::STATUS_MISSING
				: mrlp_pkg::STATUS_TIMEOUT;
			out_temp_q   <= mrlp_pkg::FAIL_VALUE;
			out_wind_q   <= mrlp_pkg::FAIL_VALUE;
		end else if (load_parse) begin
			out_status_q <= mrlp_pkg::STATUS_PARSED;
			out_temp_q   <= temp_acc_q;
			out_wind_q   <= wind_acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mrlp_pkg::BK_IDLE;
			step_q      <= 3'd0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			step_q      <= step_d;
			rd_valid_s1 <= rd_en;
			if (job_pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_temp   = out_temp_q;
	assign out_wind   = out_wind_q;

endmodule
